### design/rm2q_pkg.sv
// shared constants and types for the rotation matrix to quaternion block
`default_nettype none

package rm2q_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int N_MAT  = 9;
  localparam int IN_W   = N_MAT * DATA_W;
  localparam int OUT_W  = 4 * DATA_W;
  localparam int USER_W = 3;

  // sum of three entries, magnitude of a sum of two entries
  localparam int COMB_W = DATA_W + 2;
  localparam int T_W    = COMB_W - 1;
  localparam int MAG_W  = DATA_W + 1;

  // square root of t scaled by 2^(FRAC_BITS-2)
  localparam int SQ_IN_W    = T_W + FRAC_BITS - 2;
  localparam int SQ_ROOT_W  = (SQ_IN_W + 1) / 2;
  localparam int SQ_PAD_W   = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W   = SQ_ROOT_W + 3;
  localparam int SQ_BPS     = 3;
  localparam int SQ_STAGES  = (SQ_ROOT_W + SQ_BPS - 1) / SQ_BPS;

  // rounded division of mag << FRAC_BITS by 4 * root
  localparam int DEN_W      = SQ_ROOT_W + 2;
  localparam int NUM_W      = MAG_W + FRAC_BITS;
  localparam int Q_W        = DATA_W;
  localparam int DIV_REM_W  = DEN_W + 1;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = (Q_W + DIV_BPS - 1) / DIV_BPS;

  localparam int N_STG = 1 + SQ_STAGES + DIV_STAGES + 1;

  typedef enum logic [1:0] {
    PICK_W = 2'd0,
    PICK_X = 2'd1,
    PICK_Y = 2'd2,
    PICK_Z = 2'd3
  } pick_e;

  typedef struct packed {
    pick_e                 pick;
    logic                  invalid;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

endpackage

`default_nettype wire

### design/rotation_matrix_to_quaternion.sv
// Rotation matrix (Q1.14) to quaternion (Q1.14) by the largest-component method.
// Fully pipelined: one matrix is taken per cycle while the output is not stalled;
// its quaternion passes 1 input stage, 5 square-root stages at 3 root bits each, 4
// divider stages at 4 quotient bits each and 1 output register. Every stage
// carries its own valid bit, so a stalled output only holds back the stages
// behind it that are full. tuser reports the chosen component and a flag that
// marks a non-positive root argument (identity is then returned).
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
  input  wire logic [rm2q_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // qx, qy, qz, qw, 16 bits each
  output logic [rm2q_pkg::OUT_W-1:0]         m_axis_tdata,
  // largest_pick [1:0], invalid_flag [2]
  output logic [rm2q_pkg::USER_W-1:0]        m_axis_tuser
);
  import rm2q_pkg::*;

  localparam int ST_SQ  = 1;
  localparam int ST_DIV = ST_SQ + SQ_STAGES;
  localparam int ST_OUT = N_STG - 1;

  logic [N_STG-1:0] vld_q;
  logic [N_STG-1:0] en;

  logic [T_W-1:0]          t_f;
  side_t                   side_f, side_s, side_v;
  logic [SQ_ROOT_W-1:0]    big_s, big_v;
  logic [2:0][Q_W-1:0]     quo_v;

  logic [DATA_W-1:0]       lane_val [3];
  logic [DATA_W-1:0]       big_val;
  logic [DATA_W-1:0]       qx_d, qy_d, qz_d, qw_d;
  logic [OUT_W-1:0]        tdata_d, tdata_q;
  logic [USER_W-1:0]       tuser_d, tuser_q;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[ST_OUT] = !vld_q[ST_OUT] || m_axis_tready;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < N_STG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];

  rm2q_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .tdata_i (s_axis_tdata),
    .t_o     (t_f),
    .side_o  (side_f)
  );

  rm2q_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[ST_SQ +: SQ_STAGES]),
    .t_i    (t_f),
    .side_i (side_f),
    .big_o  (big_s),
    .side_o (side_s)
  );

  rm2q_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[ST_DIV +: DIV_STAGES]),
    .big_i  (big_s),
    .side_i (side_s),
    .quo_o  (quo_v),
    .big_o  (big_v),
    .side_o (side_v)
  );

  // saturate to one, then apply the sign
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_val[l] = (quo_v[l] > Q_W'(ONE)) ? DATA_W'(ONE) : DATA_W'(quo_v[l]);
      if (side_v.neg[l]) lane_val[l] = DATA_W'(-lane_val[l]);
    end
    big_val = (big_v > SQ_ROOT_W'(ONE)) ? DATA_W'(ONE) : DATA_W'(big_v);
  end

  always_comb begin
    case (side_v.pick)
      PICK_W: begin
        qx_d = lane_val[0]; qy_d = lane_val[1]; qz_d = lane_val[2]; qw_d = big_val;
      end
      PICK_X: begin
        qx_d = big_val; qy_d = lane_val[0]; qz_d = lane_val[1]; qw_d = lane_val[2];
      end
      PICK_Y: begin
        qx_d = lane_val[0]; qy_d = big_val; qz_d = lane_val[1]; qw_d = lane_val[2];
      end
      default: begin
        qx_d = lane_val[0]; qy_d = lane_val[1]; qz_d = big_val; qw_d = lane_val[2];
      end
    endcase
    if (side_v.invalid) begin
      tdata_d = {DATA_W'(ONE), {(3*DATA_W){1'b0}}};
      tuser_d = {1'b1, PICK_W};
    end else begin
      tdata_d = {qw_d, qz_d, qy_d, qx_d};
      tuser_d = {1'b0, side_v.pick};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid = vld_q[ST_OUT];
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // the four trace combinations sum to zero, so the root argument stays positive
  a_no_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tuser[2])
    else $error("invalid flag raised");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[DATA_W-1:0]) <= ONE) &&
      ($signed(m_axis_tdata[DATA_W-1:0]) >= -ONE) &&
      ($signed(m_axis_tdata[4*DATA_W-1:3*DATA_W]) <= ONE) &&
      ($signed(m_axis_tdata[4*DATA_W-1:3*DATA_W]) >= -ONE))
    else $error("quaternion component out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken into a full stalled pipeline");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted request lost at input stage");

endmodule

`default_nettype wire

### design/rm2q_front.sv
// input stage: trace combinations, largest pick and off-diagonal terms
`default_nettype none

module rm2q_front (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [rm2q_pkg::IN_W-1:0] tdata_i,
  output logic [rm2q_pkg::T_W-1:0]    t_o,
  output rm2q_pkg::side_t             side_o
);
  import rm2q_pkg::*;

  logic signed [DATA_W-1:0] m [N_MAT];
  logic signed [COMB_W-1:0] c0, c1, c2, c3, best01, best012, best;
  pick_e                    p01, p012, pick;
  logic signed [COMB_W:0]   tt;
  logic signed [MAG_W:0]    d_xw, d_yw, d_zw, s_01, s_02, s_12;
  logic signed [MAG_W:0]    lane [3];
  side_t                    side_d;

  logic [T_W-1:0] t_q;
  side_t          side_q;

  for (genvar k = 0; k < N_MAT; k++) begin : g_unpack
    assign m[k] = $signed(tdata_i[k*DATA_W +: DATA_W]);
  end

  assign c0 = COMB_W'(m[0]) + COMB_W'(m[4]) + COMB_W'(m[8]);
  assign c1 = COMB_W'(m[0]) - COMB_W'(m[4]) - COMB_W'(m[8]);
  assign c2 = COMB_W'(m[4]) - COMB_W'(m[0]) - COMB_W'(m[8]);
  assign c3 = COMB_W'(m[8]) - COMB_W'(m[0]) - COMB_W'(m[4]);

  // strict compare keeps ties on the earlier component
  assign best01  = (c1 > c0) ? c1 : c0;
  assign p01     = (c1 > c0) ? PICK_X : PICK_W;
  assign best012 = (c2 > best01) ? c2 : best01;
  assign p012    = (c2 > best01) ? PICK_Y : p01;
  assign best    = (c3 > best012) ? c3 : best012;
  assign pick    = (c3 > best012) ? PICK_Z : p012;

  assign tt = (COMB_W+1)'(best) + (COMB_W+1)'(ONE);

  assign d_xw = (MAG_W+1)'(m[5]) - (MAG_W+1)'(m[7]);
  assign d_yw = (MAG_W+1)'(m[6]) - (MAG_W+1)'(m[2]);
  assign d_zw = (MAG_W+1)'(m[1]) - (MAG_W+1)'(m[3]);
  assign s_01 = (MAG_W+1)'(m[1]) + (MAG_W+1)'(m[3]);
  assign s_02 = (MAG_W+1)'(m[6]) + (MAG_W+1)'(m[2]);
  assign s_12 = (MAG_W+1)'(m[5]) + (MAG_W+1)'(m[7]);

  // lanes hold the three non-chosen components in x, y, z, w order
  always_comb begin
    case (pick)
      PICK_W: begin
        lane[0] = d_xw; lane[1] = d_yw; lane[2] = d_zw;
      end
      PICK_X: begin
        lane[0] = s_01; lane[1] = s_02; lane[2] = d_xw;
      end
      PICK_Y: begin
        lane[0] = s_01; lane[1] = s_12; lane[2] = d_yw;
      end
      default: begin
        lane[0] = s_02; lane[1] = s_12; lane[2] = d_zw;
      end
    endcase
  end

  always_comb begin
    side_d.pick    = pick;
    side_d.invalid = (tt <= 0);
    for (int l = 0; l < 3; l++) begin
      side_d.neg[l] = lane[l][MAG_W];
      side_d.mag[l] = lane[l][MAG_W] ? MAG_W'(-lane[l]) : MAG_W'(lane[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= tt[T_W-1:0];
      side_q <= side_d;
    end
  end

  assign t_o    = t_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

### design/rm2q_sqrt.sv
// pipelined digit-by-digit integer square root, a few root bits per stage
`default_nettype none

module rm2q_sqrt (
  input  wire logic                                clk_i,
  input  wire logic [rm2q_pkg::SQ_STAGES-1:0]      en_i,
  input  wire logic [rm2q_pkg::T_W-1:0]            t_i,
  input  wire rm2q_pkg::side_t                     side_i,
  output logic [rm2q_pkg::SQ_ROOT_W-1:0]           big_o,
  output rm2q_pkg::side_t                          side_o
);
  import rm2q_pkg::*;

  logic [SQ_REM_W-1:0]  rem_q  [SQ_STAGES];
  logic [SQ_ROOT_W-1:0] root_q [SQ_STAGES];
  logic [T_W-1:0]       t_q    [SQ_STAGES];
  side_t                side_q [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic [SQ_REM_W-1:0]  rem_in, rem_nx;
    logic [SQ_ROOT_W-1:0] root_in, root_nx;
    logic [T_W-1:0]       t_in;
    side_t                side_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign t_in    = t_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign t_in    = t_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin : step
      logic [SQ_PAD_W-1:0] rad;
      logic [SQ_REM_W-1:0] trial;
      int                  idx;
      rad     = SQ_PAD_W'({t_in, {(FRAC_BITS-2){1'b0}}});
      trial   = '0;
      idx     = 0;
      rem_nx  = rem_in;
      root_nx = root_in;
      for (int j = 0; j < SQ_BPS; j++) begin
        idx = SQ_ROOT_W - 1 - (s * SQ_BPS + j);
        if (idx >= 0) begin
          rem_nx = {rem_nx[SQ_REM_W-3:0], rad[2*idx +: 2]};
          trial  = SQ_REM_W'({root_nx, 2'b01});
          if (rem_nx >= trial) begin
            rem_nx  = rem_nx - trial;
            root_nx = {root_nx[SQ_ROOT_W-2:0], 1'b1};
          end else begin
            root_nx = {root_nx[SQ_ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_nx;
        root_q[s] <= root_nx;
        t_q[s]    <= t_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign big_o  = root_q[SQ_STAGES-1];
  assign side_o = side_q[SQ_STAGES-1];

endmodule

`default_nettype wire

### design/rm2q_div.sv
// three-lane pipelined restoring divider, rounds to nearest by a half-divisor bias
`default_nettype none

module rm2q_div (
  input  wire logic                                 clk_i,
  input  wire logic [rm2q_pkg::DIV_STAGES-1:0]      en_i,
  input  wire logic [rm2q_pkg::SQ_ROOT_W-1:0]       big_i,
  input  wire rm2q_pkg::side_t                      side_i,
  output logic [2:0][rm2q_pkg::Q_W-1:0]             quo_o,
  output logic [rm2q_pkg::SQ_ROOT_W-1:0]            big_o,
  output rm2q_pkg::side_t                           side_o
);
  import rm2q_pkg::*;

  logic [DIV_REM_W-1:0]  rem_q  [DIV_STAGES][3];
  logic [Q_W-1:0]        quo_q  [DIV_STAGES][3];
  logic [NUM_W-1:0]      num_q  [DIV_STAGES][3];
  logic [SQ_ROOT_W-1:0]  big_q  [DIV_STAGES];
  side_t                 side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_REM_W-1:0] rem_in [3];
    logic [Q_W-1:0]       quo_in [3];
    logic [NUM_W-1:0]     num_in [3];
    logic [DIV_REM_W-1:0] rem_nx [3];
    logic [Q_W-1:0]       quo_nx [3];
    logic [SQ_ROOT_W-1:0] big_in;
    side_t                side_in;
    logic [DEN_W-1:0]     den;

    if (s == 0) begin : g_first
      assign big_in  = big_i;
      assign side_in = side_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        // add den/2 = 2 * root up front for round to nearest
        assign num_in[l] = NUM_W'({side_i.mag[l], {FRAC_BITS{1'b0}}})
                         + NUM_W'({big_i, 1'b0});
        assign rem_in[l] = DIV_REM_W'(num_in[l][NUM_W-1:Q_W]);
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign big_in  = big_q[s-1];
      assign side_in = side_q[s-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign num_in[l] = num_q[s-1][l];
        assign rem_in[l] = rem_q[s-1][l];
        assign quo_in[l] = quo_q[s-1][l];
      end
    end

    assign den = {big_in, 2'b00};

    always_comb begin : step
      int b;
      b = 0;
      for (int l = 0; l < 3; l++) begin
        rem_nx[l] = rem_in[l];
        quo_nx[l] = quo_in[l];
        for (int j = 0; j < DIV_BPS; j++) begin
          b = Q_W - 1 - (s * DIV_BPS + j);
          if (b >= 0) begin
            rem_nx[l] = {rem_nx[l][DEN_W-1:0], num_in[l][b]};
            if (rem_nx[l] >= DIV_REM_W'(den)) begin
              rem_nx[l]    = rem_nx[l] - DIV_REM_W'(den);
              quo_nx[l][b] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= rem_nx[l];
          quo_q[s][l] <= quo_nx[l];
          num_q[s][l] <= num_in[l];
        end
        big_q[s]  <= big_in;
        side_q[s] <= side_in;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = quo_q[DIV_STAGES-1][l];
  end
  assign big_o  = big_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire
